/* hw/rtl/fsfi_pkg.sv */
`default_nettype none

package fsfi_pkg;

  // Field and datapath widths.
  localparam int DATA_W    = 32;
  localparam int ACC_W     = 64;
  localparam int DIV_W     = 31;
  localparam int TC_W      = 7;
  localparam int TIDX_W    = 6;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 2;

  // Depth of the command queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // Item kinds as they arrive on the input channel.
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR   = 2'd1;

  // Saturation limits of the quotient.
  localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

  // Operations carried from the front part to the back part.
  typedef logic [1:0] op_t;
  localparam op_t OP_SAMPLE = 2'd0;
  localparam op_t OP_LOAD   = 2'd1;
  localparam op_t OP_CLEAR  = 2'd2;

  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] sample;
    logic [TIDX_W-1:0]        tap_index;
    logic signed [DATA_W-1:0] coef;
  } cmd_t;

  typedef struct packed {
    logic [TC_W-1:0]  tap_count;
    logic [DIV_W-1:0] divisor;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic             ack;
    logic [ACC_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/fsfi_front.sv */
`default_nettype none

module fsfi_front
  import fsfi_pkg::*;
#(
  parameter int MAX_TAPS = 64
) (
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [KIND_W-1:0]        in_kind,
  input  wire logic signed [DATA_W-1:0] in_sample,
  input  wire logic [TIDX_W-1:0]        in_tap_index,
  input  wire logic signed [DATA_W-1:0] in_coefficient,
  input  wire logic                     q_full,
  output logic                          q_push,
  output cmd_t                          q_data
);

  logic keep;

  // Items that change nothing are accepted and dropped here.
  always_comb begin
    q_data.sample    = in_sample;
    q_data.tap_index = in_tap_index;
    q_data.coef      = in_coefficient;
    q_data.op        = OP_SAMPLE;
    keep             = 1'b0;
    unique case (in_kind)
      KIND_SAMPLE: begin
        q_data.op = OP_SAMPLE;
        keep      = 1'b1;
      end
      KIND_LOAD: begin
        q_data.op = OP_LOAD;
        keep      = (32'(in_tap_index) < MAX_TAPS);
      end
      KIND_CLEAR: begin
        q_data.op = OP_CLEAR;
        keep      = 1'b1;
      end
      default: begin
        q_data.op = OP_SAMPLE;
        keep      = 1'b0;
      end
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;

endmodule

`default_nettype wire

/* hw/rtl/fsfi_queue.sv */
`default_nettype none

module fsfi_queue
  import fsfi_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      push_data,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             do_pop;

  assign full       = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/fsfi_div.sv */
`default_nettype none

module fsfi_div
  import fsfi_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  div_req_t  req,
  output div_rsp_t  rsp
);

  localparam int CNT_W = $clog2(ACC_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ACC_W - 1);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_RUN  = 2'd1;
  localparam logic [1:0] D_SAT  = 2'd2;
  localparam logic [1:0] D_DONE = 2'd3;

  logic [1:0]        dstate_r;
  logic [1:0]        dstate_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [ACC_W-1:0]  quo_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  rem_nxt;
  logic [DIV_W-1:0]  d_r;
  logic              neg_r;
  logic [DATA_W-1:0] res_r;
  logic [DATA_W-1:0] res_nxt;
  logic [DIV_W:0]    rem_sh;
  logic [DIV_W:0]    diff;
  logic              ge;
  logic              pos_ovf;
  logic              neg_ovf;

  // One quotient bit per cycle, restoring form. The remainder stays below
  // the divisor, so it fits the divisor's width.
  always_comb begin
    rem_sh  = {rem_r, quo_r[ACC_W-1]};
    diff    = rem_sh - {1'b0, d_r};
    ge      = (rem_sh >= {1'b0, d_r});
    rem_nxt = ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
  end

  always_comb begin
    pos_ovf = |quo_r[ACC_W-1:DATA_W-1];
    neg_ovf = (|quo_r[ACC_W-1:DATA_W]) || (quo_r[DATA_W-1] && (|quo_r[DATA_W-2:0]));
    if (!neg_r) begin
      res_nxt = pos_ovf ? SAT_POS : quo_r[DATA_W-1:0];
    end else begin
      res_nxt = neg_ovf ? SAT_NEG : (32'd0 - quo_r[DATA_W-1:0]);
    end
  end

  always_comb begin
    dstate_nxt = dstate_r;
    unique case (dstate_r)
      D_IDLE: if (req.start) dstate_nxt = D_RUN;
      D_RUN:  if (cnt_r == LAST_STEP) dstate_nxt = D_SAT;
      D_SAT:  dstate_nxt = D_DONE;
      D_DONE: if (req.ack) dstate_nxt = D_IDLE;
      default: dstate_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dstate_r <= D_IDLE;
    end else begin
      dstate_r <= dstate_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dstate_r == D_IDLE && req.start) begin
      quo_r <= req.dividend[ACC_W-1] ? (64'd0 - req.dividend) : req.dividend;
      rem_r <= '0;
      d_r   <= req.divisor;
      neg_r <= req.dividend[ACC_W-1];
      cnt_r <= '0;
    end else if (dstate_r == D_RUN) begin
      quo_r <= {quo_r[ACC_W-2:0], ge};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
    if (dstate_r == D_SAT) begin
      res_r <= res_nxt;
    end
  end

  assign rsp.busy     = (dstate_r != D_IDLE);
  assign rsp.done     = (dstate_r == D_DONE);
  assign rsp.quotient = res_r;

endmodule

`default_nettype wire

/* hw/rtl/fsfi_back.sv */
`default_nettype none

module fsfi_back
  import fsfi_pkg::*;
#(
  parameter int MAX_TAPS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  cfg_t                    cfg,
  input  wire logic               q_valid,
  input  cmd_t                    q_head,
  output logic                    q_pop,
  output div_req_t                div_req,
  input  div_rsp_t                div_rsp,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [DATA_W-1:0] out_filtered
);

  localparam int AW = $clog2(MAX_TAPS);
  localparam int CW = $clog2(MAX_TAPS + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_TAPS - 1);
  localparam logic [CW-1:0] FILL_MAX  = CW'(MAX_TAPS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MAC   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DIV   = 2'd3;

  logic [1:0]               state_r;
  logic [1:0]               state_nxt;
  logic [AW-1:0]            wp_r;
  logic [CW-1:0]            fill_r;
  logic [AW-1:0]            k_r;
  logic [AW-1:0]            slot_r;
  logic [AW-1:0]            last_r;
  logic [AW-1:0]            n_last;
  logic                     rd_v_r;
  logic                     age_ok_r;
  logic                     prod_v_r;
  logic signed [ACC_W-1:0]  prod_r;
  logic [ACC_W-1:0]         acc_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_filtered_r;
  logic signed [DATA_W-1:0] tap_q_r;
  logic signed [DATA_W-1:0] hist_q_r;
  logic signed [DATA_W-1:0] hist_sel;
  logic [31:0]              tc_w;
  logic                     dispatch;
  logic                     is_sample;
  logic                     tap_we;
  logic                     hist_we;
  logic                     issue;
  logic                     pipe_empty;
  logic                     out_free;
  logic                     out_load;

  logic signed [DATA_W-1:0] taps_mem [MAX_TAPS];
  logic signed [DATA_W-1:0] hist_mem [MAX_TAPS];

  // Tap count zero runs one tap; counts above the ring depth run the ring.
  always_comb begin
    tc_w = 32'(cfg.tap_count);
    if (tc_w == 32'd0) begin
      n_last = '0;
    end else if (tc_w > MAX_TAPS) begin
      n_last = LAST_SLOT;
    end else begin
      n_last = AW'(tc_w - 32'd1);
    end
  end

  assign dispatch   = (state_r == S_IDLE) && q_valid;
  assign is_sample  = (q_head.op == OP_SAMPLE);
  assign q_pop      = dispatch;
  assign tap_we     = dispatch && (q_head.op == OP_LOAD);
  assign hist_we    = dispatch && is_sample;
  assign issue      = (state_r == S_MAC);
  assign pipe_empty = !rd_v_r && !prod_v_r;
  assign out_free   = !out_valid_r || !out_stall;
  assign out_load   = (state_r == S_DIV) && div_rsp.done && out_free;
  assign hist_sel   = age_ok_r ? hist_q_r : '0;

  assign div_req.start    = (state_r == S_DRAIN) && pipe_empty;
  assign div_req.ack      = out_load;
  assign div_req.dividend = acc_r;
  assign div_req.divisor  = (cfg.divisor == '0) ? 31'd1 : cfg.divisor;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (q_valid && is_sample) state_nxt = S_MAC;
      S_MAC:   if (k_r == last_r) state_nxt = S_DRAIN;
      S_DRAIN: if (pipe_empty) state_nxt = S_DIV;
      S_DIV:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      rd_v_r      <= 1'b0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_v_r   <= issue;
      prod_v_r <= rd_v_r;
      if (dispatch) begin
        unique case (q_head.op)
          OP_SAMPLE: begin
            wp_r   <= (wp_r == LAST_SLOT) ? '0 : (wp_r + 1'b1);
            fill_r <= (fill_r == FILL_MAX) ? fill_r : (fill_r + 1'b1);
          end
          OP_CLEAR: begin
            wp_r   <= '0;
            fill_r <= '0;
          end
          default: begin
            wp_r <= wp_r;
          end
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Sequencer walks ages from zero upward; the slot walks the ring backward.
  always_ff @(posedge clk) begin
    if (hist_we) begin
      k_r    <= '0;
      slot_r <= wp_r;
      last_r <= n_last;
    end else if (issue) begin
      k_r    <= k_r + 1'b1;
      slot_r <= (slot_r == '0) ? LAST_SLOT : (slot_r - 1'b1);
    end
    age_ok_r <= (CW'(k_r) < fill_r);
    prod_r   <= tap_q_r * hist_sel;
    if (hist_we) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + prod_r;
    end
    if (out_load) begin
      out_filtered_r <= div_rsp.quotient;
    end
  end

  always_ff @(posedge clk) begin
    if (tap_we) begin
      taps_mem[AW'(q_head.tap_index)] <= q_head.coef;
    end
    tap_q_r <= taps_mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[wp_r] <= q_head.sample;
    end
    hist_q_r <= hist_mem[slot_r];
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;

  assert property (@(posedge clk) disable iff (!rst_n) fill_r <= FILL_MAX)
    else $error("history fill count beyond ring depth");

  assert property (@(posedge clk) disable iff (!rst_n) wp_r <= LAST_SLOT)
    else $error("write position outside the ring");

  assert property (@(posedge clk) disable iff (!rst_n) rd_v_r |-> $past(state_r) == S_MAC)
    else $error("memory read flagged outside the tap sequence");

  assert property (@(posedge clk) disable iff (!rst_n) div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

endmodule

`default_nettype wire

/* hw/rtl/fir_filter_scaled_int.sv */
// Integer FIR filter with a configurable tap count and output divisor.
// Input channel (in_valid / in_stall): each item is a sample, a coefficient
// load or a history clear, chosen by in_kind. Only sample items give a
// result item on the output channel (out_valid / out_stall). Kind three and
// loads to a tap index beyond the ring are accepted and dropped.
// Configuration port (cfg_valid / cfg_ready): cfg_ready is always high;
// index 0 writes tap_count, index 1 writes output_divisor. Write it only
// while the block is idle.
// Sequence: the back end applies a load or clear as it takes it from the queue.
// A sample runs one tap per cycle on the shared multiply-accumulate, which
// reads one coefficient and one history word a cycle, then drains that
// pipeline (memory read, product, accumulate) and runs the bit-serial divider
// plus saturation. A two-entry queue lets the front keep accepting while the
// back works.
// Reset clears the history (through a fill count), the write position and the
// configuration (64 taps, divisor 1); coefficients are undefined until loaded.
// When the receiver stalls, the result holds in the output register; the next
// sample runs its taps and divide and then waits for that register to free.
`default_nettype none

module fir_filter_scaled_int
  import fsfi_pkg::*;
#(
  parameter int MAX_TAPS = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [KIND_W-1:0]        in_kind,
  input  wire logic signed [DATA_W-1:0] in_sample,
  input  wire logic [TIDX_W-1:0]        in_tap_index,
  input  wire logic signed [DATA_W-1:0] in_coefficient,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      out_filtered,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [DIV_W-1:0]         cfg_data
);

  logic [TC_W-1:0]  tap_count_r;
  logic [DIV_W-1:0] divisor_r;
  cfg_t             cfg;
  logic             q_full;
  logic             q_push;
  cmd_t             q_data;
  logic             q_pop;
  logic             q_valid;
  cmd_t             q_head;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  // Configuration registers; writes to unknown indexes are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TC_W'(64);
      divisor_r   <= DIV_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_TAP_COUNT) begin
        tap_count_r <= cfg_data[TC_W-1:0];
      end else if (cfg_index == CFG_DIVISOR) begin
        divisor_r <= cfg_data;
      end
    end
  end

  assign cfg.tap_count = tap_count_r;
  assign cfg.divisor   = divisor_r;

  fsfi_front #(
    .MAX_TAPS(MAX_TAPS)
  ) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_sample     (in_sample),
    .in_tap_index  (in_tap_index),
    .in_coefficient(in_coefficient),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_data)
  );

  fsfi_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head      (q_head)
  );

  fsfi_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  fsfi_back #(
    .MAX_TAPS(MAX_TAPS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .div_req     (div_req),
    .div_rsp     (div_rsp),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_filtered(out_filtered)
  );

endmodule

`default_nettype wire
